@@ sv/imu_fusion_pkg.sv @@
// imu_fusion_pkg: shared types and constants for the quaternion fusion block.
// No dependencies.
package imu_fusion_pkg;
	localparam int MAG_W = 64;
	typedef logic [MAG_W-1:0] mag_t;
	typedef struct packed {
		logic start;
		logic busy;
	} ctl_t;
endpackage

@@ sv/imu_fusion_div.sv @@
// imu_fusion_div: shared restoring divider / square root unit, one bit per cycle.
// Depends on imu_fusion_pkg.
module imu_fusion_div import imu_fusion_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	input  logic sqrt_mode,
	input  mag_t num,
	input  mag_t den,
	output logic done,
	output mag_t res
);
	logic [6:0] cnt_q;
	logic busy_q;
	mag_t rem_q, quo_q, den_q, x_q, bit_q;
	logic [MAG_W:0] trial;
	mag_t tsq;
	logic mode_q;
	always_comb begin
		trial = {rem_q, quo_q[MAG_W-1]} - {1'b0, den_q};
		tsq = res + bit_q;
	end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done <= 1'b0;
			cnt_q <= '0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				mode_q <= sqrt_mode;
				cnt_q <= sqrt_mode ? 7'd32 : 7'd64;
				rem_q <= '0;
				quo_q <= num;
				den_q <= den;
				x_q <= num;
				bit_q <= mag_t'(1) << 62;
				res <= '0;
			end else if (busy_q) begin
				if (mode_q) begin
					if (x_q >= tsq) begin
						x_q <= x_q - tsq;
						res <= (res >> 1) + bit_q;
					end else
						res <= res >> 1;
					bit_q <= bit_q >> 2;
				end else begin
					if (!trial[MAG_W]) begin
						rem_q <= trial[MAG_W-1:0];
						quo_q <= {quo_q[MAG_W-2:0], 1'b1};
					end else begin
						rem_q <= {rem_q[MAG_W-2:0], quo_q[MAG_W-1]};
						quo_q <= {quo_q[MAG_W-2:0], 1'b0};
					end
				end
				cnt_q <= cnt_q - 7'd1;
				if (cnt_q == 7'd1) begin
					busy_q <= 1'b0;
					done <= 1'b1;
					if (!mode_q) res <= !trial[MAG_W] ? {quo_q[MAG_W-2:0], 1'b1}
						: {quo_q[MAG_W-2:0], 1'b0};
				end
			end
		end
	end
endmodule

@@ sv/imu_quaternion_fusion.sv @@
// imu_quaternion_fusion: six-axis gradient-descent orientation filter, Q2.30.
// Depends on imu_fusion_pkg and imu_fusion_div.
//
// channel   | dir | fields
// s_axis    | in  | tdata: accel_x,y,z (16b each), rate_x,y,z (24b each), step_time (24b)
// m_axis    | out | tdata: quat_w,x,y,z (32b each); tuser: skipped
// beta cfg  | in  | beta_we / beta_data (Q0.16)
//
// A full update runs three normalizations (sum of squares, a 32-step square root
// and a 64-step division per component on the shared divider) and 36 multiply
// steps, each a low and a high half (one 20 x 33 bit partial product per cycle).
// A zero gradient skips its normalization; a zero accelerometer skips the update
// and gives the unchanged quaternion with tuser set. Reset gives the identity
// quaternion and beta 6554.
// The result waits in an output register; the next request is taken once it has left.
module imu_quaternion_fusion import imu_fusion_pkg::*; #(
	parameter int FRAC_BITS = 30
) (
	input  logic clk,
	input  logic arst_n,
	input  logic s_axis_tvalid,
	output logic s_axis_tready,
	input  logic [143:0] s_axis_tdata, // accel_x,accel_y,accel_z,rate_x,rate_y,rate_z,step_time
	output logic m_axis_tvalid,
	input  logic m_axis_tready,
	output logic [127:0] m_axis_tdata, // quat_w,quat_x,quat_y,quat_z
	output logic m_axis_tuser,         // skipped
	input  logic beta_we,
	input  logic [15:0] beta_data
);
	localparam logic [4:0] ST_IDLE = 5'd0, ST_NRM = 5'd1, ST_SQ = 5'd2, ST_SQW = 5'd3,
		ST_DIV = 5'd4, ST_DIVW = 5'd5, ST_MUL = 5'd6, ST_OUT = 5'd7,
		ST_SCL = 5'd8, ST_SUM = 5'd9, ST_FIN = 5'd10;
	localparam logic [1:0] PH_ACC = 2'd0, PH_GRAD = 2'd1, PH_Q = 2'd2;

	logic [4:0] st_q;
	logic [1:0] ph_q;
	logic [15:0] beta_q;
	logic signed [63:0] q_q [4];
	logic signed [63:0] v_q [4];   // vector being normalized
	logic signed [63:0] n_q [4];   // normalized result
	logic signed [63:0] f_q [3];
	logic signed [63:0] gr_q [4];
	logic signed [23:0] g_q [3];
	logic [23:0] dt_q;
	logic [2:0] nv_q, idx_q;
	logic [5:0] mstep_q;
	mag_t m_q [4];
	mag_t sum_q, r_q;
	logic [59:0] sq;
	logic ok_q;
	logic out_v_q;

	// one shared rounding multiplier: round(a*b/2^sh), ties away from zero
	// |a| < 2^40, |b| < 2^33; the low half of a is registered first, the high half is added after it
	logic signed [63:0] ma, mb, mres;
	logic [4:0] msh;
	logic [39:0] mua;
	logic [32:0] mub;
	logic [52:0] mlo, mhi, mlo_q;
	mag_t mp, mpr;
	logic mneg, mph_q;
	always_comb begin
		mneg = (ma < 0) != (mb < 0);
		mua = 40'(ma < 0 ? -ma : ma);
		mub = 33'(mb < 0 ? -mb : mb);
		mlo = mua[19:0] * mub;
		mhi = mua[39:20] * mub;
		mp = mag_t'(mlo_q) + (mag_t'(mhi) << 20);
		mpr = (mp + (mag_t'(1) << (msh - 5'd1))) >> msh;
		mres = mneg ? -$signed(mpr) : $signed(mpr);
	end

	logic dv_start, dv_sqrt, dv_done;
	mag_t dv_num, dv_den, dv_res;
	imu_fusion_div u_div (.clk, .arst_n, .start(dv_start), .sqrt_mode(dv_sqrt),
		.num(dv_num), .den(dv_den), .done(dv_done), .res(dv_res));

	// block scaling of the largest magnitude into [2^29, 2^30)
	mag_t mx;
	logic [6:0] lz;
	always_comb begin
		mx = '0;
		for (int i = 0; i < 4; i++)
			if (i < nv_q && m_q[i] > mx) mx = m_q[i];
		lz = 7'd0;
		for (int b = 0; b < MAG_W; b++) if (mx[b]) lz = 7'(b);
	end

	// scaled magnitudes stay below 2^30
	assign sq = m_q[idx_q[1:0]][29:0] * m_q[idx_q[1:0]][29:0];

	// multiply schedule for the error, gradient and rate steps
	always_comb begin
		ma = '0; mb = '0; msh = 5'(FRAC_BITS);
		case (mstep_q)
			6'd0:  begin ma = 2*q_q[1]; mb = q_q[3]; end
			6'd1:  begin ma = 2*q_q[0]; mb = q_q[2]; end
			6'd2:  begin ma = 2*q_q[0]; mb = q_q[1]; end
			6'd3:  begin ma = 2*q_q[2]; mb = q_q[3]; end
			6'd4:  begin ma = 2*q_q[1]; mb = q_q[1]; end
			6'd5:  begin ma = 2*q_q[2]; mb = q_q[2]; end
			6'd6:  begin ma = 2*q_q[1]; mb = f_q[1]; end
			6'd7:  begin ma = 2*q_q[2]; mb = f_q[0]; end
			6'd8:  begin ma = 2*q_q[3]; mb = f_q[0]; end
			6'd9:  begin ma = 2*q_q[0]; mb = f_q[1]; end
			6'd10: begin ma = 4*q_q[1]; mb = f_q[2]; end
			6'd11: begin ma = 2*q_q[3]; mb = f_q[1]; end
			6'd12: begin ma = 4*q_q[2]; mb = f_q[2]; end
			6'd13: begin ma = 2*q_q[0]; mb = f_q[0]; end
			6'd14: begin ma = 2*q_q[1]; mb = f_q[0]; end
			6'd15: begin ma = 2*q_q[2]; mb = f_q[1]; end
			6'd16: begin ma = q_q[1]; mb = g_q[0]; msh = 5'd17; end
			6'd17: begin ma = q_q[2]; mb = g_q[1]; msh = 5'd17; end
			6'd18: begin ma = q_q[3]; mb = g_q[2]; msh = 5'd17; end
			6'd19: begin ma = q_q[0]; mb = g_q[0]; msh = 5'd17; end
			6'd20: begin ma = q_q[2]; mb = g_q[2]; msh = 5'd17; end
			6'd21: begin ma = q_q[3]; mb = g_q[1]; msh = 5'd17; end
			6'd22: begin ma = q_q[0]; mb = g_q[1]; msh = 5'd17; end
			6'd23: begin ma = q_q[1]; mb = g_q[2]; msh = 5'd17; end
			6'd24: begin ma = q_q[3]; mb = g_q[0]; msh = 5'd17; end
			6'd25: begin ma = q_q[0]; mb = g_q[2]; msh = 5'd17; end
			6'd26: begin ma = q_q[1]; mb = g_q[1]; msh = 5'd17; end
			6'd27: begin ma = q_q[2]; mb = g_q[0]; msh = 5'd17; end
			6'd28, 6'd30, 6'd32, 6'd34: begin
				ma = $signed({48'd0, beta_q}); mb = n_q[mstep_q[2:1] - 2'd2];
				msh = 5'd16;
			end
			6'd29, 6'd31, 6'd33, 6'd35: begin
				ma = gr_q[mstep_q[2:1] - 2'd2]; mb = $signed({40'd0, dt_q});
				msh = 5'd24;
			end
			default: ;
		endcase
	end

	assign s_axis_tready = (st_q == ST_IDLE) && !out_v_q;
	assign m_axis_tvalid = out_v_q;
	assign m_axis_tdata = {q_q[3][31:0], q_q[2][31:0], q_q[1][31:0], q_q[0][31:0]};

	always_comb begin
		dv_start = 1'b0; dv_sqrt = 1'b0; dv_num = sum_q; dv_den = r_q;
		if (st_q == ST_SQ) begin dv_start = 1'b1; dv_sqrt = 1'b1; end
		if (st_q == ST_DIV) begin dv_start = 1'b1; dv_num = m_q[idx_q[1:0]] << FRAC_BITS; end
	end

	logic [6:0] up, dn;
	always_comb begin
		up = (lz < 7'd29) ? 7'd29 - lz : 7'd0;
		dn = (lz > 7'd29) ? lz - 7'd29 : 7'd0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_IDLE;
			beta_q <= 16'd6554;
			q_q[0] <= 64'sd1 <<< FRAC_BITS;
			q_q[1] <= '0; q_q[2] <= '0; q_q[3] <= '0;
			out_v_q <= 1'b0;
			mph_q <= 1'b0;
			m_axis_tuser <= 1'b0;
		end else begin
			if (beta_we) beta_q <= beta_data;
			if (out_v_q && m_axis_tready) out_v_q <= 1'b0;
			case (st_q)
				ST_IDLE: if (s_axis_tvalid && s_axis_tready) begin
					for (int i = 0; i < 3; i++) begin
						v_q[i] <= 64'($signed(s_axis_tdata[16*i +: 16]));
						g_q[i] <= s_axis_tdata[48+24*i +: 24];
					end
					v_q[3] <= '0;
					dt_q <= s_axis_tdata[120 +: 24];
					nv_q <= 3'd3; ph_q <= PH_ACC;
					st_q <= ST_NRM;
				end
				ST_NRM: begin
					// magnitudes, then scale on the next cycle
					for (int i = 0; i < 4; i++) m_q[i] <= v_q[i] < 0 ? -v_q[i] : v_q[i];
					idx_q <= 3'd0; sum_q <= '0;
					st_q <= ST_SCL;
				end
				ST_SCL: begin
					if (mx == 0) begin
						ok_q <= 1'b0; st_q <= ST_FIN;
					end else begin
						for (int i = 0; i < 4; i++) m_q[i] <= (m_q[i] >> dn) << up;
						idx_q <= 3'd0; st_q <= ST_SUM;
					end
				end
				ST_SUM: begin // sum of squares, one term per cycle
					sum_q <= sum_q + mag_t'(sq);
					idx_q <= idx_q + 3'd1;
					if (idx_q + 3'd1 == nv_q) st_q <= ST_SQ;
				end
				ST_SQ: st_q <= ST_SQW;
				ST_SQW: if (dv_done) begin r_q <= dv_res; idx_q <= 3'd0; st_q <= ST_DIV; end
				ST_DIV: st_q <= ST_DIVW;
				ST_DIVW: if (dv_done) begin
					n_q[idx_q[1:0]] <= v_q[idx_q[1:0]] < 0 ? -$signed(dv_res) : $signed(dv_res);
					idx_q <= idx_q + 3'd1;
					if (idx_q + 3'd1 == nv_q) begin ok_q <= 1'b1; st_q <= ST_FIN; end
					else st_q <= ST_DIV;
				end
				ST_FIN: begin // normalization finished
					case (ph_q)
						PH_ACC: if (!ok_q) begin
							m_axis_tuser <= 1'b1; st_q <= ST_OUT;
						end else begin
							f_q[0] <= -n_q[0]; f_q[1] <= -n_q[1];
							f_q[2] <= (64'sd1 <<< FRAC_BITS) - n_q[2];
							for (int i = 0; i < 4; i++) gr_q[i] <= '0;
							mstep_q <= 6'd0; st_q <= ST_MUL;
						end
						PH_GRAD: begin
							if (!ok_q) for (int i = 0; i < 4; i++) n_q[i] <= '0;
							for (int i = 0; i < 4; i++) gr_q[i] <= '0;
							mstep_q <= 6'd16; st_q <= ST_MUL;
						end
						default: begin
							if (ok_q) for (int i = 0; i < 4; i++) q_q[i] <= n_q[i];
							m_axis_tuser <= 1'b0; st_q <= ST_OUT;
						end
					endcase
				end
				ST_MUL: if (!mph_q) begin
					mlo_q <= mlo;
					mph_q <= 1'b1;
				end else begin
					mph_q <= 1'b0;
					mstep_q <= mstep_q + 6'd1;
					case (mstep_q)
						6'd0: f_q[0] <= f_q[0] + mres;
						6'd1: f_q[0] <= f_q[0] - mres;
						6'd2, 6'd3: f_q[1] <= f_q[1] + mres;
						6'd4, 6'd5: f_q[2] <= f_q[2] - mres;
						6'd6: gr_q[0] <= gr_q[0] + mres;
						6'd7: gr_q[0] <= gr_q[0] - mres;
						6'd8, 6'd9: gr_q[1] <= gr_q[1] + mres;
						6'd10: gr_q[1] <= gr_q[1] - mres;
						6'd11: gr_q[2] <= gr_q[2] + mres;
						6'd12, 6'd13: gr_q[2] <= gr_q[2] - mres;
						6'd14: gr_q[3] <= gr_q[3] + mres;
						6'd15: begin
							for (int i = 0; i < 3; i++) v_q[i] <= gr_q[i];
							v_q[3] <= gr_q[3] + mres;
							nv_q <= 3'd4; ph_q <= PH_GRAD; st_q <= ST_NRM;
						end
						6'd16, 6'd17, 6'd18: gr_q[0] <= gr_q[0] - mres;
						6'd19, 6'd20: gr_q[1] <= gr_q[1] + mres;
						6'd21: gr_q[1] <= gr_q[1] - mres;
						6'd22, 6'd24: gr_q[2] <= gr_q[2] + mres;
						6'd23: gr_q[2] <= gr_q[2] - mres;
						6'd25, 6'd26: gr_q[3] <= gr_q[3] + mres;
						6'd27: gr_q[3] <= gr_q[3] - mres;
						6'd28, 6'd30, 6'd32, 6'd34:
							gr_q[mstep_q[2:1] - 2'd2] <= gr_q[mstep_q[2:1] - 2'd2] - mres;
						6'd29, 6'd31, 6'd33:
							v_q[mstep_q[2:1] - 2'd2] <= q_q[mstep_q[2:1] - 2'd2] + mres;
						6'd35: begin
							v_q[3] <= q_q[3] + mres;
							nv_q <= 3'd4; ph_q <= PH_Q; st_q <= ST_NRM;
						end
						default: ;
					endcase
				end
				ST_OUT: begin out_v_q <= 1'b1; st_q <= ST_IDLE; end
				default: st_q <= ST_IDLE;
			endcase
		end
	end
endmodule

@@ sv/imu_fusion_chk.sv @@
// imu_fusion_chk: port-level checks for imu_quaternion_fusion, bound to the top.
// Depends on nothing beyond the top level's ports.
module imu_fusion_chk (
	input logic clk,
	input logic arst_n,
	input logic s_axis_tvalid,
	input logic s_axis_tready,
	input logic m_axis_tvalid,
	input logic m_axis_tready,
	input logic [127:0] m_axis_tdata,
	input logic m_axis_tuser
);
	a_no_accept_while_out: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> !s_axis_tready) else $error("request taken with result pending");
	a_out_holds: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
		else $error("result changed under stall");
	a_busy_after_take: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
		else $error("ready right after request");
	a_skip_keeps: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser |-> m_axis_tdata[31:0] != 32'h8000_0000)
		else $error("bad skipped result");
endmodule

bind imu_quaternion_fusion imu_fusion_chk u_chk (.clk, .arst_n, .s_axis_tvalid,
	.s_axis_tready, .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser);

@@ test/testbench.sv @@
// testbench: random and directed check of imu_quaternion_fusion against an
// in-bench fixed-point predictor of the six-axis orientation update.
// Depends on imu_fusion_pkg and the block's RTL.
`timescale 1ns / 1ps

typedef struct {
	logic [31:0] w, x, y, z;
	logic        skip;
} quat_res_t;

// Predicts the orientation after each accepted request and checks results.
class orient_scoreboard;
	localparam int FB = 30;
	longint    orient[4];
	longint    beta;
	quat_res_t pending_q[$];
	int        errors;
	int        checked;
	int        skips;

	function new();
		orient = '{64'sd1 << FB, 0, 0, 0};
		beta = 6554;
		errors = 0;
		checked = 0;
		skips = 0;
	endfunction

	function longint unsigned umag(longint a);
		return (a < 0) ? longint'(0) - a : a;
	endfunction

	// round(a*b / 2^sh), ties away from zero
	function longint mul_rnd(longint a, longint b, int sh);
		bit neg;
		longint unsigned p;
		neg = (a < 0) != (b < 0);
		p = umag(a) * umag(b);
		p = (p + (64'd1 << (sh - 1))) >> sh;
		return neg ? -longint'(p) : longint'(p);
	endfunction

	function longint unsigned floor_sqrt(longint unsigned x);
		longint unsigned r, b;
		r = 0;
		b = 64'h4000_0000_0000_0000;
		while (b > x)
			b >>= 2;
		while (b != 0) begin
			if (x >= r + b) begin
				x -= r + b;
				r = (r >> 1) + b;
			end else begin
				r >>= 1;
			end
			b >>= 2;
		end
		return r;
	endfunction

	// block-scaled unit vector; returns 0 for an all-zero vector
	function bit unit_vec(longint v[4], int n, output longint o[4]);
		longint unsigned m[4], mx, sum, r;
		int up, down;
		mx = 0; sum = 0; up = 0; down = 0;
		o = '{0, 0, 0, 0};
		for (int i = 0; i < n; i++) begin
			m[i] = umag(v[i]);
			if (m[i] > mx) mx = m[i];
		end
		if (mx == 0) return 0;
		while (mx >= (64'd1 << 30)) begin mx >>= 1; down++; end
		while (mx < (64'd1 << 29)) begin mx <<= 1; up++; end
		for (int i = 0; i < n; i++) begin
			m[i] = (m[i] >> down) << up;
			sum += m[i] * m[i];
		end
		r = floor_sqrt(sum);
		for (int i = 0; i < n; i++)
			o[i] = (v[i] < 0) ? -longint'((m[i] << FB) / r) : longint'((m[i] << FB) / r);
		return 1;
	endfunction

	function void note_request(logic [15:0] ax, ay, az, logic [23:0] gx, gy, gz,
			logic [23:0] dt_in);
		longint acc[4], an[4], g[3], f1, f2, f3, grad[4], h[4], qd[4], nq[4], nn[4];
		longint q1, q2, q3, q4, t1, t2, t3, t4, dt, d;
		quat_res_t e;
		bit skip;
		q1 = orient[0]; q2 = orient[1]; q3 = orient[2]; q4 = orient[3];
		t1 = 2 * q1; t2 = 2 * q2; t3 = 2 * q3; t4 = 2 * q4;
		acc = '{longint'($signed(ax)), longint'($signed(ay)), longint'($signed(az)), 0};
		g = '{longint'($signed(gx)), longint'($signed(gy)), longint'($signed(gz))};
		dt = longint'({40'd0, dt_in});
		skip = !unit_vec(acc, 3, an);
		if (!skip) begin
			f1 = mul_rnd(t2, q4, FB) - mul_rnd(t1, q3, FB) - an[0];
			f2 = mul_rnd(t1, q2, FB) + mul_rnd(t3, q4, FB) - an[1];
			f3 = (64'sd1 << FB) - mul_rnd(t2, q2, FB) - mul_rnd(t3, q3, FB) - an[2];
			grad[0] = mul_rnd(t2, f2, FB) - mul_rnd(t3, f1, FB);
			grad[1] = mul_rnd(t4, f1, FB) + mul_rnd(t1, f2, FB) - mul_rnd(2 * t2, f3, FB);
			grad[2] = mul_rnd(t4, f2, FB) - mul_rnd(2 * t3, f3, FB) - mul_rnd(t1, f1, FB);
			grad[3] = mul_rnd(t2, f1, FB) + mul_rnd(t3, f2, FB);
			// zero gradient leaves h at zero: pure gyro integration
			void'(unit_vec(grad, 4, h));
			qd[0] = -mul_rnd(q2, g[0], 17) - mul_rnd(q3, g[1], 17) - mul_rnd(q4, g[2], 17);
			qd[1] = mul_rnd(q1, g[0], 17) + mul_rnd(q3, g[2], 17) - mul_rnd(q4, g[1], 17);
			qd[2] = mul_rnd(q1, g[1], 17) - mul_rnd(q2, g[2], 17) + mul_rnd(q4, g[0], 17);
			qd[3] = mul_rnd(q1, g[2], 17) + mul_rnd(q2, g[1], 17) - mul_rnd(q3, g[0], 17);
			for (int i = 0; i < 4; i++) begin
				d = qd[i] - mul_rnd(beta, h[i], 16);
				nq[i] = orient[i] + mul_rnd(d, dt, 24);
			end
			// all-zero integrated quaternion keeps the old state
			if (unit_vec(nq, 4, nn))
				orient = nn;
		end
		e.w = orient[0][31:0];
		e.x = orient[1][31:0];
		e.y = orient[2][31:0];
		e.z = orient[3][31:0];
		e.skip = skip;
		pending_q.push_back(e);
	endfunction

	function void check_result(logic [127:0] data, logic user);
		quat_res_t e, a;
		a.w = data[31:0]; a.x = data[63:32]; a.y = data[95:64]; a.z = data[127:96];
		a.skip = user;
		if (pending_q.size() == 0) begin
			$display("%0t: unexpected result w=%h x=%h y=%h z=%h skipped=%b",
				$time, a.w, a.x, a.y, a.z, a.skip);
			errors++;
			return;
		end
		e = pending_q.pop_front();
		checked++;
		if (e.skip) skips++;
		if (a.w !== e.w) begin
			$display("%0t: quat_w expected %h actual %h", $time, e.w, a.w); errors++;
		end
		if (a.x !== e.x) begin
			$display("%0t: quat_x expected %h actual %h", $time, e.x, a.x); errors++;
		end
		if (a.y !== e.y) begin
			$display("%0t: quat_y expected %h actual %h", $time, e.y, a.y); errors++;
		end
		if (a.z !== e.z) begin
			$display("%0t: quat_z expected %h actual %h", $time, e.z, a.z); errors++;
		end
		if (a.skip !== e.skip) begin
			$display("%0t: skipped expected %b actual %b", $time, e.skip, a.skip); errors++;
		end
	endfunction
endclass

module testbench;
	import imu_fusion_pkg::*;

	localparam longint CYCLE_LIMIT = 40_000_000;
	localparam int     RAND_ITEMS = 578;

	logic          clk;
	logic          arst_n;
	logic          s_axis_tvalid;
	logic          s_axis_tready;
	logic [143:0]  s_axis_tdata; // accel_x,y,z (16b), rate_x,y,z (24b), step_time (24b)
	logic          m_axis_tvalid;
	logic          m_axis_tready;
	logic [127:0]  m_axis_tdata; // quat_w, quat_x, quat_y, quat_z
	logic          m_axis_tuser; // skipped
	logic          beta_we;
	logic [15:0]   beta_data;

	orient_scoreboard sb;
	int     send_idle_pct;
	int     recv_idle_pct;
	int     recv_hold;   // long receiver stall, counted down by the receiver
	longint cycles;
	int     sent;

	imu_quaternion_fusion i_dut (
		.clk(clk), .arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
		.beta_we(beta_we), .beta_data(beta_data)
	);

	initial begin
		clk = 0;
		forever #1 clk = ~clk;
	end

	// watchdog
	initial cycles = 0;
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("testbench: FAIL");
			$finish;
		end
	end

	// receiver: checks every accepted result, then decides next tready
	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready)
			sb.check_result(m_axis_tdata, m_axis_tuser);
		if (recv_hold > 0) begin
			recv_hold <= recv_hold - 1;
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	// one request: random idle gap, then hold valid until accepted
	task automatic send_sample(logic [15:0] ax, ay, az, logic [23:0] gx, gy, gz,
			logic [23:0] dt);
		while ($urandom_range(99) < send_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {dt, gz, gy, gx, az, ay, ax};
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		sb.note_request(ax, ay, az, gx, gy, gz, dt);
		sent++;
	endtask

	task automatic drain();
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (sb.pending_q.size() != 0) @(posedge clk);
		repeat (50) @(posedge clk);
	endtask

	// only called with the block idle
	task automatic write_beta(logic [15:0] v);
		beta_we <= 1'b1;
		beta_data <= v;
		@(posedge clk);
		beta_we <= 1'b0;
		sb.beta = longint'({48'd0, v});
		@(posedge clk);
	endtask

	function automatic logic [23:0] rand_rate();
		case ($urandom_range(9))
			0:       return 24'($urandom());                  // full Q7.16 range
			1:       return 24'd0;
			default: return 24'($signed($urandom_range(524288)) - 262144); // +-4 rad/s
		endcase
	endfunction

	function automatic logic [15:0] rand_accel();
		case ($urandom_range(15))
			0:       return 16'd0;
			1:       return 16'($signed($urandom_range(6)) - 3);
			default: return 16'($urandom());
		endcase
	endfunction

	task automatic random_run(int n);
		logic [15:0] ax, ay, az;
		logic [23:0] dt;
		for (int i = 0; i < n; i++) begin
			ax = rand_accel(); ay = rand_accel(); az = rand_accel();
			// mostly a level sensor near gravity so the estimate settles
			if ($urandom_range(3) != 0) begin
				ax = 16'($signed($urandom_range(4000)) - 2000);
				ay = 16'($signed($urandom_range(4000)) - 2000);
				az = 16'(16384 + $signed($urandom_range(2000)) - 1000);
			end
			if ($urandom_range(40) == 0) begin ax = '0; ay = '0; az = '0; end
			case ($urandom_range(7))
				0:       dt = 24'($urandom());
				1:       dt = 24'd0;
				default: dt = 24'($urandom_range(335544)); // up to 20 ms
			endcase
			send_sample(ax, ay, az, rand_rate(), rand_rate(), rand_rate(), dt);
		end
	endtask

	initial begin
		sb = new();
		s_axis_tvalid = 0;
		s_axis_tdata = '0;
		m_axis_tready = 0;
		beta_we = 0;
		beta_data = '0;
		recv_hold = 0;
		sent = 0;
		send_idle_pct = 33;
		recv_idle_pct = 62;
		arst_n = 0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: reset beta first
		send_sample(16'd0, 16'd0, 16'd16384, 24'd0, 24'd0, 24'd0, 24'd167772); // zero gradient
		send_sample(16'd0, 16'd0, 16'd0, 24'd65536, 24'd0, 24'd0, 24'd167772); // zero accel
		send_sample(16'h7fff, 16'h7fff, 16'h7fff, 24'h7fffff, 24'h7fffff, 24'h7fffff,
			24'hffffff);
		send_sample(16'h8000, 16'h8000, 16'h8000, 24'h800000, 24'h800000, 24'h800000,
			24'hffffff);
		send_sample(16'd1, 16'd0, 16'd0, 24'd100000, 24'hff0000, 24'd3, 24'd1);
		send_sample(16'h8000, 16'h7fff, 16'd1, 24'h000001, 24'hffffff, 24'd0, 24'd0);
		drain();
		write_beta(16'd0);
		send_sample(16'd100, 16'd200, 16'd16000, 24'd50000, 24'hfe0000, 24'd70000,
			24'd335544);
		send_sample(16'd0, 16'd0, 16'd0, 24'd0, 24'd0, 24'd0, 24'd0);
		send_sample(16'hc000, 16'd0, 16'd4000, 24'd0, 24'd0, 24'd0, 24'hffffff);
		drain();
		write_beta(16'hffff);
		send_sample(16'd100, 16'hff00, 16'd9000, 24'd20000, 24'd0, 24'hff8000,
			24'd335544);
		send_sample(16'd0, 16'd16384, 16'd0, 24'd0, 24'd0, 24'd0, 24'h800000);
		send_sample(16'h8000, 16'd0, 16'd0, 24'h7fffff, 24'd0, 24'h800000, 24'hffffff);
		send_sample(16'd0, 16'd0, 16'd0, 24'd1, 24'd1, 24'd1, 24'd1);
		random_run(RAND_ITEMS);
		drain();

		// sender stalls more than the receiver
		send_idle_pct = 62;
		recv_idle_pct = 33;
		write_beta(16'd6554);
		random_run(RAND_ITEMS);
		drain();

		// back to back, with one long receiver stall first
		send_idle_pct = 0;
		recv_idle_pct = 0;
		write_beta(16'($urandom()));
		recv_hold = 6000;
		random_run(RAND_ITEMS);
		drain();

		$display("covered %0d requests (%0d with zero accelerometer) over four gain settings",
			sent, sb.skips);
		$display("%0d results compared, %0d mismatches", sb.checked, sb.errors);
		if (sb.errors == 0 && sb.pending_q.size() == 0)
			$display("testbench: PASS");
		else
			$display("testbench: FAIL");
		$finish;
	end
endmodule
